// ===== rtl/lmsu_pkg.sv =====
// Package for the loop marker snap unit: request/response types, command codes, FSM states.
package lmsu_pkg;

    localparam int TICK_W = 32;
    localparam int SNAP_W = 16;
    localparam int MEAS_W = 24;
    localparam int SNAP_STEPS_SHIFT = 2;   // four snaps = snap << 2
    localparam int CNT_W = $clog2(TICK_W);

    typedef enum logic [1:0] {
        KIND_SET_LEFT   = 2'd0,
        KIND_SET_RIGHT  = 2'd1,
        KIND_SNAP_LEFT  = 2'd2,
        KIND_SNAP_RIGHT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROUND,
        ST_FINISH
    } state_t;

    typedef struct packed {
        kind_t               kind;
        logic [TICK_W-1:0]   tick;
        logic [SNAP_W-1:0]   snap;
    } req_t;

    typedef struct packed {
        logic [TICK_W-1:0]   left_marker;
        logic [TICK_W-1:0]   right_marker;
        logic [TICK_W-1:0]   start_marker;
        logic [TICK_W-1:0]   snapped_tick;
        logic                bad_snap;
    } rsp_t;

    // saturating add at the tick range
    function automatic logic [TICK_W-1:0] sat_add(
        input logic [TICK_W-1:0] a,
        input logic [TICK_W-1:0] b
    );
        logic [TICK_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TICK_W] ? {TICK_W{1'b1}} : sum[TICK_W-1:0];
    endfunction

endpackage

// ===== rtl/loop_marker_snap_unit.sv =====
// Loop marker snap unit: left/right/start loop markers with grid snapping.
//
// One request in, one response out. Exact set-left/set-right requests and snap
// requests with a zero snap skip the divider and go from acceptance straight
// to the finish state, which fills the response register. Snap requests run a
// bit-serial remainder (tick mod snap), one dividend bit per cycle: accept,
// divide, rounding and commit. A snap-left that crosses the right marker rounds
// a second value through the same divider before commit. A new request is
// taken once the unit is back in idle; a finished response waits in the output
// register and the unit stalls at commit only if that register is still full.
// measure_length is written through cfg_we/cfg_wdata and must only change
// while the unit is idle.
module loop_marker_snap_unit
    import lmsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [MEAS_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  req_t              in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rsp_t              out_data
);

    state_t              state_reg, state_next;
    logic [MEAS_W-1:0]   measure_reg;
    logic [TICK_W-1:0]   left_reg, left_next;
    logic [TICK_W-1:0]   right_reg, right_next;
    logic [TICK_W-1:0]   start_reg, start_next;
    logic                out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                cross_reg, cross_next;

    // payload registers
    kind_t               kind_reg, kind_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [SNAP_W-1:0]   snap_reg, snap_next;
    logic [TICK_W-1:0]   x_reg, x_next;       // value being rounded
    logic [TICK_W-1:0]   dvd_reg, dvd_next;   // dividend shift register
    logic [SNAP_W-1:0]   rem_reg, rem_next;   // partial remainder
    logic [TICK_W-1:0]   t_reg, t_next;       // snap-left rounded tick
    logic [TICK_W-1:0]   r_reg, r_next;       // snap-right rounded tick
    rsp_t                out_reg, out_next;

    logic [SNAP_W:0]     rem_shift;
    logic [TICK_W-1:0]   rounded;
    logic [TICK_W-1:0]   meas_ext;
    logic [TICK_W-1:0]   set_right_t;
    logic                commit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign meas_ext  = {{(TICK_W-MEAS_W){1'b0}}, measure_reg};

    always_comb
    begin
        logic [SNAP_W-1:0] up_amt;
        up_amt    = snap_reg - rem_reg;
        rem_shift = {rem_reg, dvd_reg[TICK_W-1]};
        // exactly half (rounded down) rounds down
        if (rem_reg > (snap_reg >> 1))
            rounded = sat_add(x_reg, {{(TICK_W-SNAP_W){1'b0}}, up_amt});
        else
            rounded = x_reg - {{(TICK_W-SNAP_W){1'b0}}, rem_reg};
        set_right_t = (tick_reg == '0) ? meas_ext : tick_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        start_next     = start_reg;
        cnt_next       = cnt_reg;
        cross_next     = cross_reg;
        kind_next      = kind_reg;
        tick_next      = tick_reg;
        snap_next      = snap_reg;
        x_next         = x_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        t_next         = t_reg;
        r_next         = r_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        commit         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = in_data.kind;
                    tick_next  = in_data.tick;
                    snap_next  = in_data.snap;
                    x_next     = in_data.tick;
                    dvd_next   = in_data.tick;
                    rem_next   = '0;
                    cnt_next   = '0;
                    cross_next = 1'b0;
                    if ((in_data.kind inside {KIND_SET_LEFT, KIND_SET_RIGHT})
                        || in_data.snap == '0)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                // restoring step: remainder stays below snap
                if (rem_shift >= {1'b0, snap_reg})
                    rem_next = SNAP_W'(rem_shift - {1'b0, snap_reg});
                else
                    rem_next = rem_shift[SNAP_W-1:0];
                dvd_next = {dvd_reg[TICK_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TICK_W-1))
                    state_next = ST_ROUND;
            end

            ST_ROUND:
            begin
                if (kind_reg == KIND_SNAP_LEFT && !cross_reg)
                begin
                    t_next = rounded;
                    if (right_reg <= rounded)
                    begin
                        // markers cross: round t + 4 snaps for the right marker
                        x_next   = sat_add(rounded, {{(TICK_W-SNAP_W-SNAP_STEPS_SHIFT){1'b0}},
                                                     snap_reg, {SNAP_STEPS_SHIFT{1'b0}}});
                        dvd_next = x_next;
                        rem_next = '0;
                        cnt_next = '0;
                        cross_next = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                        state_next = ST_FINISH;
                end
                else
                begin
                    r_next     = rounded;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    out_next.snapped_tick = tick_reg;
                    out_next.bad_snap     = 1'b0;
                    if (kind_reg == KIND_SET_LEFT)
                    begin
                        left_next  = tick_reg;
                        start_next = tick_reg;
                        if (tick_reg >= right_reg)
                            right_next = sat_add(tick_reg, meas_ext);
                    end
                    else if (kind_reg == KIND_SET_RIGHT)
                    begin
                        if (set_right_t >= meas_ext)
                        begin
                            right_next = set_right_t;
                            if (set_right_t <= left_reg)
                            begin
                                left_next  = set_right_t - meas_ext;
                                start_next = set_right_t - meas_ext;
                            end
                        end
                    end
                    else if (snap_reg == '0)
                        out_next.bad_snap = 1'b1;
                    else if (kind_reg == KIND_SNAP_LEFT)
                    begin
                        if (cross_reg && r_reg > left_reg)
                            right_next = r_reg;
                        left_next  = t_reg;
                        start_next = t_reg;
                        out_next.snapped_tick = t_reg;
                    end
                    else
                    begin
                        if (r_reg > left_reg)
                        begin
                            right_next = r_reg;
                            start_next = left_reg;
                        end
                        out_next.snapped_tick = r_reg;
                    end
                    out_next.left_marker  = left_next;
                    out_next.right_marker = right_next;
                    out_next.start_marker = start_next;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            measure_reg   <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            cross_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
                measure_reg <= cfg_wdata;
            left_reg      <= left_next;
            right_reg     <= right_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            cross_reg     <= cross_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        tick_reg <= tick_next;
        snap_reg <= snap_next;
        x_reg    <= x_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        t_reg    <= t_next;
        r_reg    <= r_next;
        out_reg  <= out_next;
    end

`ifndef NO_ASSERTIONS
    // divider remainder must stay below the grid while dividing or rounding
    a_rem_below_snap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_ROUND) |-> rem_reg < snap_reg)
        else $error("remainder not below snap");

    // an accepted request always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg != ST_IDLE)
        else $error("request accepted but unit stayed idle");

    // a commit always presents a response on the next cycle
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid)
        else $error("commit without response");

    // snap-right needs a single divide pass
    a_snap_right_one_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && kind_reg == KIND_SNAP_RIGHT) |=> state_reg == ST_FINISH)
        else $error("snap-right did not finish after rounding");
`endif

endmodule
